>>> sv/xor_parity_fec_encoder_defines.svh
// Assertion macros of the XOR parity FEC encoder RTL.
// Included by the top level; depends on nothing else.
`ifndef XOR_PARITY_FEC_ENCODER_DEFINES_SVH
`define XOR_PARITY_FEC_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define XPFE_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define XPFE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/xpfe_pkg.sv
// Shared constants, types and helpers of the XOR parity FEC encoder.
// Used by the channel interfaces, the byte lanes, the merge stage and the top.
package xpfe_pkg;

   localparam int MAX_PAYLOAD_WORDS = 64;
   // Byte length of a group; covers 8 * MAX_PAYLOAD_WORDS over the whole range
   localparam int LEN_W             = 10;
   localparam int LANES             = 8;
   localparam int NB_W              = 4;
   localparam int CSR_AW            = 3;
   localparam int CSR_DW            = 32;

   localparam logic [7:0]      GROUP_PKTS_RESET = 8'd4;
   localparam logic [NB_W-1:0] BYTES_PER_WORD   = 4'd8;

   typedef enum logic [0:0] {
      REG_GROUP_PKTS  = 1'b0,
      REG_PARITY_SSRC = 1'b1
   } reg_index_type;

   typedef enum logic [0:0] {
      ST_COLLECT = 1'b0,
      ST_DRAIN   = 1'b1
   } state_type;

   // Per-word control that every byte lane and the merge stage see
   typedef struct packed {
      logic [LEN_W-1:0] start;
      logic [LEN_W-1:0] length;
      logic [NB_W-1:0]  nb;
   } lane_ctl_type;

   // Clamp a byte count to one word
   function automatic logic [NB_W-1:0] clamp_bytes(input logic [NB_W-1:0] nb);
      clamp_bytes = (nb > BYTES_PER_WORD) ? BYTES_PER_WORD : nb;
   endfunction

endpackage

>>> sv/xpfe_req_if.sv
// Media payload word channel of the XOR parity FEC encoder.
// Depends on xpfe_pkg for field widths.
interface xpfe_req_if;
   logic                        valid;
   logic                        ready;
   logic [15:0]                 seq_number;
   logic [63:0]                 data_word;
   logic [xpfe_pkg::NB_W-1:0]   valid_bytes;
   logic                        end_of_packet;

   modport source (output valid, seq_number, data_word, valid_bytes, end_of_packet,
                   input ready);
   modport sink   (input valid, seq_number, data_word, valid_bytes, end_of_packet,
                   output ready);
endinterface

>>> sv/xpfe_rsp_if.sv
// Parity word channel of the XOR parity FEC encoder.
// Depends on xpfe_pkg for field widths.
interface xpfe_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [15:0]                 parity_seq;
   logic [15:0]                 group_base_seq;
   logic [31:0]                 stream_id;
   logic [63:0]                 parity_word;
   logic [xpfe_pkg::NB_W-1:0]   word_bytes;
   logic                        last_word;
   logic                        truncated;

   modport source (output valid, parity_seq, group_base_seq, stream_id, parity_word,
                   word_bytes, last_word, truncated,
                   input ready);
   modport sink   (input valid, parity_seq, group_base_seq, stream_id, parity_word,
                   word_bytes, last_word, truncated,
                   output ready);
endinterface

>>> sv/xpfe_lane.sv
// One byte lane: folds one incoming byte into the stored parity byte.
// Depends on xpfe_pkg (lane_ctl_type).
module xpfe_lane #(
   parameter int LANE = 0
) (
   input  xpfe_pkg::lane_ctl_type ctl,
   input  logic [7:0]             old_byte,
   input  logic [7:0]             new_byte,
   output logic [7:0]             lane_byte
);

   logic [xpfe_pkg::LEN_W:0] pos;
   logic                     keep_old;
   logic                     keep_new;

   // Stored byte counts only below the group length; new byte only below nb
   assign pos       = {1'b0, ctl.start} + (xpfe_pkg::LEN_W + 1)'(LANE);
   assign keep_old  = pos < {1'b0, ctl.length};
   assign keep_new  = xpfe_pkg::NB_W'(LANE) < ctl.nb;
   assign lane_byte = (keep_old ? old_byte : 8'h00) ^ (keep_new ? new_byte : 8'h00);

endmodule

>>> sv/xpfe_merge.sv
// Merge stage: packs the lane bytes into a word and grows the group length.
// Depends on xpfe_pkg (lane_ctl_type, widths).
module xpfe_merge (
   input  xpfe_pkg::lane_ctl_type         ctl,
   input  logic                           in_range,
   input  logic [7:0]                     lane_byte [xpfe_pkg::LANES],
   output logic [63:0]                    merged_word,
   output logic [xpfe_pkg::LEN_W-1:0]     length_next
);

   logic [xpfe_pkg::LEN_W:0] word_end;
   logic                     grows;

   // Pack lanes, first byte in the low bits
   always_comb begin
      for (int i = 0; i < xpfe_pkg::LANES; i++) begin
         merged_word[8*i +: 8] = lane_byte[i];
      end
   end

   // Extend the length to the end of this word's valid bytes
   assign word_end    = {1'b0, ctl.start} + (xpfe_pkg::LEN_W + 1)'(ctl.nb);
   assign grows       = in_range && (ctl.nb != '0) && (word_end > {1'b0, ctl.length});
   assign length_next = grows ? word_end[xpfe_pkg::LEN_W-1:0] : ctl.length;

endmodule

>>> sv/xor_parity_fec_encoder.sv
// Top level of the XOR parity FEC encoder: control, parity store, drain, CSRs.
// Depends on xpfe_pkg, xpfe_req_if, xpfe_rsp_if, xpfe_lane, xpfe_merge and the
// assertion macros in xor_parity_fec_encoder_defines.svh.
//
//   channel   direction  contents
//   req_bus   in         media payload word: seq, 8 data bytes, byte count, end flag
//   rsp_bus   out        parity word: parity seq, base seq, stream id, data, flags
//   csr_*     in         APB register port: packets per group at 0x0, parity_ssrc at 0x4
//
// Media words are taken one per cycle; each is read from the parity store at
// acceptance and written back in the next cycle, with the write forwarded to a
// following read of the same entry. The word that closes a group blocks input
// during its write-back, then for the drain: one parity word per cycle through the
// store's single read port, slower while rsp_bus stalls.
// Reset is synchronous and clears control state; the store is not cleared.
`include "xor_parity_fec_encoder_defines.svh"

module xor_parity_fec_encoder #(
   parameter int MAX_PAYLOAD_WORDS = xpfe_pkg::MAX_PAYLOAD_WORDS
) (
   input  logic                           clock,
   input  logic                           reset,
   xpfe_req_if.sink                       req_bus,
   xpfe_rsp_if.source                     rsp_bus,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [xpfe_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [xpfe_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [xpfe_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                           csr_pready
);

   localparam int WPW   = $clog2(MAX_PAYLOAD_WORDS + 1);
   localparam int AW    = (MAX_PAYLOAD_WORDS > 1) ? $clog2(MAX_PAYLOAD_WORDS) : 1;
   localparam int LEN_W = xpfe_pkg::LEN_W;
   localparam int NB_W  = xpfe_pkg::NB_W;

   // Configuration registers
   logic [7:0]                 gsize_ff;
   logic [31:0]                ssrc_ff;
   xpfe_pkg::reg_index_type    csr_index;
   logic                       csr_write;

   // Group state
   xpfe_pkg::state_type        state_ff, state_in;
   logic [WPW-1:0]             wp_ff;
   logic [7:0]                 pig_ff;
   logic [15:0]                base_ff;
   logic [15:0]                pseq_ff;
   logic                       ovf_ff;
   logic [LEN_W-1:0]           len_ff;

   // Stage 1 (word accepted, store read in flight)
   logic                       s1_valid_ff;
   logic                       s1_close_ff;
   logic                       s1_inrange_ff;
   logic [AW-1:0]              s1_addr_ff;
   logic [LEN_W-1:0]           s1_start_ff;
   logic [63:0]                s1_data_ff;
   logic [NB_W-1:0]            s1_nb_ff;
   logic                       fwd_hit_ff;
   logic [63:0]                fwd_data_ff;

   // Parity store
   logic [63:0]                store [MAX_PAYLOAD_WORDS];
   logic [63:0]                rd_data_ff;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic                       wr_en;

   // Drain
   logic [WPW-1:0]             k_ff;
   logic                       pend_ff;
   logic [WPW-1:0]             pend_k_ff;
   logic [LEN_W:0]             word_sum;
   logic [WPW-1:0]             word_count;
   logic [WPW-1:0]             emit_count;
   logic [LEN_W-1:0]           rem_bytes;
   logic [NB_W-1:0]            out_bytes;
   logic [63:0]                out_word;
   logic                       drain_issue;
   logic                       drain_move;
   logic                       drain_done;

   // Output register
   logic                       out_valid_ff;
   logic [15:0]                out_pseq_ff;
   logic [15:0]                out_base_ff;
   logic [31:0]                out_ssrc_ff;
   logic [63:0]                out_word_ff;
   logic [NB_W-1:0]            out_bytes_ff;
   logic                       out_last_ff;
   logic                       out_trunc_ff;

   // Input side
   logic                       req_accept;
   logic                       in_range;
   logic [NB_W-1:0]            nb_clamp;
   logic [7:0]                 limit;
   logic [7:0]                 pig_next;
   logic                       closes;

   // Lane datapath
   xpfe_pkg::lane_ctl_type     lane_ctl;
   logic [63:0]                old_word;
   logic [7:0]                 lane_byte [xpfe_pkg::LANES];
   logic [63:0]                merged_word;
   logic [LEN_W-1:0]           length_next;

   // ---------------------------------------------------------------- CSR port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = xpfe_pkg::reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         gsize_ff <= xpfe_pkg::GROUP_PKTS_RESET;
         ssrc_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            xpfe_pkg::REG_GROUP_PKTS:  gsize_ff <= csr_pwdata[7:0];
            xpfe_pkg::REG_PARITY_SSRC: ssrc_ff  <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         xpfe_pkg::REG_GROUP_PKTS:  csr_prdata = {24'h000000, gsize_ff};
         xpfe_pkg::REG_PARITY_SSRC: csr_prdata = ssrc_ff;
         default:                   csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- input decode
   assign in_range = wp_ff < WPW'(MAX_PAYLOAD_WORDS);
   assign nb_clamp = xpfe_pkg::clamp_bytes(req_bus.valid_bytes);
   assign limit    = (gsize_ff == 8'd0) ? 8'd1 : gsize_ff;
   assign pig_next = pig_ff + 8'd1;
   assign closes   = req_bus.end_of_packet && ((pig_next >= limit) || (pig_next == 8'd0));

   // ----------------------------------------------------- control and drain
   always_comb begin
      state_in      = state_ff;
      req_bus.ready = 1'b0;
      drain_move    = pend_ff && (!out_valid_ff || rsp_bus.ready);
      drain_issue   = 1'b0;
      drain_done    = 1'b0;
      case (state_ff)
         xpfe_pkg::ST_COLLECT: begin
            // Hold input while the closing word finishes its write-back
            req_bus.ready = !(s1_valid_ff && s1_close_ff);
            if (s1_valid_ff && s1_close_ff) begin
               state_in = xpfe_pkg::ST_DRAIN;
            end
         end
         xpfe_pkg::ST_DRAIN: begin
            drain_issue = (k_ff < emit_count) && (!pend_ff || drain_move);
            drain_done  = (k_ff == emit_count) && !pend_ff;
            if (drain_done) begin
               state_in = xpfe_pkg::ST_COLLECT;
            end
         end
         default: state_in = xpfe_pkg::ST_COLLECT;
      endcase
   end

   assign req_accept = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xpfe_pkg::ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Group bookkeeping at word acceptance and at drain end
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         pig_ff  <= '0;
         base_ff <= '0;
         pseq_ff <= '0;
         ovf_ff  <= 1'b0;
      end else if (drain_done) begin
         pseq_ff <= pseq_ff + 16'd1;
         ovf_ff  <= 1'b0;
      end else if (req_accept) begin
         if (pig_ff == 8'd0 && wp_ff == '0) begin
            base_ff <= req_bus.seq_number;
         end
         if (!in_range) begin
            ovf_ff <= 1'b1;
         end
         if (req_bus.end_of_packet) begin
            wp_ff  <= '0;
            pig_ff <= closes ? 8'd0 : pig_next;
         end else if (in_range) begin
            wp_ff <= wp_ff + WPW'(1);
         end
      end
   end

   // Stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_close_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
         if (req_accept) begin
            s1_close_ff <= closes;
            fwd_hit_ff  <= wr_en && (s1_addr_ff == wp_ff[AW-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_inrange_ff <= in_range;
         s1_addr_ff    <= wp_ff[AW-1:0];
         s1_start_ff   <= LEN_W'({wp_ff, 3'b000});
         s1_data_ff    <= req_bus.data_word;
         s1_nb_ff      <= nb_clamp;
         fwd_data_ff   <= merged_word;
      end
   end

   // ------------------------------------------------------------ byte lanes
   assign old_word = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
   assign lane_ctl = '{start: s1_start_ff, length: len_ff, nb: s1_nb_ff};

   for (genvar g = 0; g < xpfe_pkg::LANES; g++) begin : g_lane
      xpfe_lane #(
         .LANE (g)
      ) u_lane (
         .ctl       (lane_ctl),
         .old_byte  (old_word[8*g +: 8]),
         .new_byte  (s1_data_ff[8*g +: 8]),
         .lane_byte (lane_byte[g])
      );
   end

   xpfe_merge u_merge (
      .ctl         (lane_ctl),
      .in_range    (s1_inrange_ff),
      .lane_byte   (lane_byte),
      .merged_word (merged_word),
      .length_next (length_next)
   );

   // Group length: grow in write-back, clear after drain
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (drain_done) begin
         len_ff <= '0;
      end else if (s1_valid_ff) begin
         len_ff <= length_next;
      end
   end

   // ----------------------------------------------------------- parity store
   assign wr_en   = s1_valid_ff && s1_inrange_ff;
   assign rd_en   = req_accept || drain_issue;
   assign rd_addr = (state_ff == xpfe_pkg::ST_DRAIN) ? k_ff[AW-1:0] : wp_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[s1_addr_ff] <= merged_word;
      end
      if (rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   // ------------------------------------------------------------ drain path
   assign word_sum   = {1'b0, len_ff} + (LEN_W + 1)'(7);
   assign word_count = WPW'(word_sum >> 3);
   assign emit_count = (word_count == '0) ? WPW'(1) : word_count;
   assign rem_bytes  = len_ff - LEN_W'({pend_k_ff, 3'b000});
   assign out_bytes  = (rem_bytes > LEN_W'(xpfe_pkg::BYTES_PER_WORD)) ?
                       xpfe_pkg::BYTES_PER_WORD : rem_bytes[NB_W-1:0];

   // Drop bytes past the word's count
   always_comb begin
      for (int i = 0; i < xpfe_pkg::LANES; i++) begin
         out_word[8*i +: 8] = (NB_W'(i) < out_bytes) ? rd_data_ff[8*i +: 8] : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff      <= '0;
         pend_ff   <= 1'b0;
         pend_k_ff <= '0;
      end else if (drain_done) begin
         k_ff <= '0;
      end else if (drain_issue) begin
         k_ff      <= k_ff + WPW'(1);
         pend_k_ff <= k_ff;
         pend_ff   <= 1'b1;
      end else if (drain_move) begin
         pend_ff <= 1'b0;
      end
   end

   // ---------------------------------------------------------- output word
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (drain_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (drain_move) begin
         out_pseq_ff  <= pseq_ff;
         out_base_ff  <= base_ff;
         out_ssrc_ff  <= ssrc_ff;
         out_word_ff  <= out_word;
         out_bytes_ff <= out_bytes;
         out_last_ff  <= (pend_k_ff + WPW'(1)) == emit_count;
         out_trunc_ff <= ovf_ff;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.parity_seq     = out_pseq_ff;
   assign rsp_bus.group_base_seq = out_base_ff;
   assign rsp_bus.stream_id      = out_ssrc_ff;
   assign rsp_bus.parity_word    = out_word_ff;
   assign rsp_bus.word_bytes     = out_bytes_ff;
   assign rsp_bus.last_word      = out_last_ff;
   assign rsp_bus.truncated      = out_trunc_ff;

   // ------------------------------------------------------------ assertions
   `XPFE_ASSERT_IMPLY(a_close_blocks_input, clock, reset,
      s1_valid_ff && s1_close_ff, !req_accept,
      "word accepted behind a group-closing word")
   `XPFE_ASSERT_IMPLY(a_drain_count_bound, clock, reset,
      state_ff == xpfe_pkg::ST_DRAIN, k_ff <= emit_count,
      "drain read count past parity length")
   `XPFE_ASSERT_NEXT(a_drain_exit_clean, clock, reset,
      drain_done, !pend_ff && (k_ff == '0) && (len_ff == '0),
      "group state not cleared after drain")

endmodule

>>> bench/xpfe_parity_checker.sv
// Parity checker for the XOR parity FEC encoder: watches the media word,
// parity word and register ports, predicts every parity word and compares.
// Depends on xpfe_pkg, xpfe_req_if and xpfe_rsp_if.
module xpfe_parity_checker (
   input  logic                        clock,
   input  logic                        reset,
   xpfe_req_if                         req_mon,
   xpfe_rsp_if                         rsp_mon,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [xpfe_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [xpfe_pkg::CSR_DW-1:0] csr_pwdata,
   input  logic                        csr_pready,
   output int unsigned                 mismatches,
   output int unsigned                 parity_backlog
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDX_W = $clog2(xpfe_pkg::MAX_PAYLOAD_WORDS);

   typedef struct packed {
      logic [15:0] parity_seq;
      logic [15:0] grp_base;
      logic [31:0] stream_id;
      logic [63:0] payload;
      logic [3:0]  nbytes;
      logic        is_last;
      logic        trunc;
   } parity_word_type;

   // Register copies
   logic [7:0]  grp_size;
   logic [31:0] ssrc;

   // Group state
   logic [63:0] parity_acc [xpfe_pkg::MAX_PAYLOAD_WORDS];
   logic [9:0]  group_len;
   logic [7:0]  pkt_count;
   logic [6:0]  word_pos;
   logic [15:0] first_seq;
   logic [15:0] next_pseq;
   logic        overflow;

   parity_word_type pending_parity [$];

   function automatic logic [63:0] byte_mask(input int unsigned n);
      if (n >= 8) return '1;
      return (64'd1 << (8 * n)) - 64'd1;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want_v,
                                       input logic [63:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         mismatches++;
      end
   endfunction

   // Fold one media word into the group; emit the parity packet when the group closes
   task automatic fold_media_word(input logic [15:0] seq, input logic [63:0] data,
                                  input logic [3:0] nb_raw, input logic eop);
      int unsigned nb, limit, start, words, remain;
      logic [63:0] prior;
      parity_word_type pw;
      nb    = (nb_raw > 4'd8) ? 8 : nb_raw;
      limit = (grp_size == 8'd0) ? 1 : grp_size;
      if (pkt_count == 8'd0 && word_pos == 7'd0)
         first_seq = seq;

      // Merge the word, or drop it past the store and flag truncation
      if (word_pos < xpfe_pkg::MAX_PAYLOAD_WORDS) begin
         start = word_pos * 8;
         prior = '0;
         if (start < group_len)
            prior = parity_acc[word_pos[IDX_W-1:0]] & byte_mask(group_len - start);
         parity_acc[word_pos[IDX_W-1:0]] = prior ^ (data & byte_mask(nb));
         if (nb > 0 && start + nb > group_len)
            group_len = 10'(start + nb);
         word_pos++;
      end else begin
         overflow = 1'b1;
      end

      if (!eop) return;
      word_pos  = '0;
      pkt_count = pkt_count + 8'd1;
      if (pkt_count < limit && pkt_count != 8'd0) return;

      // Drain the parity packet
      words = (group_len + 7) / 8;
      if (words > xpfe_pkg::MAX_PAYLOAD_WORDS) words = xpfe_pkg::MAX_PAYLOAD_WORDS;
      pw.parity_seq = next_pseq;
      pw.grp_base   = first_seq;
      pw.stream_id  = ssrc;
      pw.trunc      = overflow;
      if (words == 0) begin
         pw.payload = '0;
         pw.nbytes  = '0;
         pw.is_last = 1'b1;
         pending_parity.push_back(pw);
      end else begin
         for (int k = 0; k < words; k++) begin
            remain     = group_len - 8 * k;
            if (remain > 8) remain = 8;
            pw.payload = parity_acc[IDX_W'(k)] & byte_mask(remain);
            pw.nbytes  = 4'(remain);
            pw.is_last = (k + 1 == words);
            pending_parity.push_back(pw);
         end
      end
      next_pseq = next_pseq + 16'd1;
      pkt_count = '0;
      group_len = '0;
      overflow  = 1'b0;
   endtask

   always @(posedge clock) begin
      parity_word_type want;
      if (reset) begin
         grp_size  = xpfe_pkg::GROUP_PKTS_RESET;
         ssrc      = '0;
         group_len = '0;
         pkt_count = '0;
         word_pos  = '0;
         first_seq = '0;
         next_pseq = '0;
         overflow  = 1'b0;
         pending_parity.delete();
         mismatches     = 0;
         parity_backlog = 0;
      end else begin
         // Compare each parity word against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_parity.size() == 0) begin
               $error("parity word seq %0h arrived with none expected", rsp_mon.parity_seq);
               mismatches++;
            end else begin
               want = pending_parity.pop_front();
               check_field("parity_seq", 64'(want.parity_seq), 64'(rsp_mon.parity_seq));
               check_field("group_base_seq", 64'(want.grp_base),
                           64'(rsp_mon.group_base_seq));
               check_field("stream_id", 64'(want.stream_id), 64'(rsp_mon.stream_id));
               check_field("parity_word", want.payload, rsp_mon.parity_word);
               check_field("word_bytes", 64'(want.nbytes), 64'(rsp_mon.word_bytes));
               check_field("last_word", 64'(want.is_last), 64'(rsp_mon.last_word));
               check_field("truncated", 64'(want.trunc), 64'(rsp_mon.truncated));
            end
         end

         if (req_mon.valid && req_mon.ready)
            fold_media_word(req_mon.seq_number, req_mon.data_word, req_mon.valid_bytes,
                            req_mon.end_of_packet);

         // Track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (xpfe_pkg::reg_index_type'(csr_paddr[2]))
               xpfe_pkg::REG_GROUP_PKTS: begin
                  grp_size = csr_pwdata[7:0];
               end
               xpfe_pkg::REG_PARITY_SSRC: begin
                  ssrc = csr_pwdata;
               end
               default: begin
               end
            endcase
         end

         parity_backlog = pending_parity.size();
      end
   end

endmodule

>>> bench/tb.sv
// Top of the XOR parity FEC encoder bench: clock, reset, media word stimulus,
// register writes, random stalls and the verdict.
// Depends on xpfe_pkg, both channel interfaces, the encoder and xpfe_parity_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset;

   xpfe_req_if req_bus ();
   xpfe_rsp_if rsp_bus ();

   logic                        csr_psel;
   logic                        csr_penable;
   logic                        csr_pwrite;
   logic [xpfe_pkg::CSR_AW-1:0] csr_paddr;
   logic [xpfe_pkg::CSR_DW-1:0] csr_pwdata;
   logic [xpfe_pkg::CSR_DW-1:0] csr_prdata;
   logic                        csr_pready;

   int unsigned mismatches;
   int unsigned parity_backlog;
   int unsigned send_gap_pct;
   int unsigned recv_stall_pct;
   int unsigned words_sent;
   logic [15:0] media_seq;

   xor_parity_fec_encoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   xpfe_parity_checker u_parity_chk (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatches     (mismatches),
      .parity_backlog (parity_backlog)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stall the parity word channel at random
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Hard stop for a hung run
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Setup and access cycle, with an idle gap first so psel falls between writes
   task automatic write_reg(input xpfe_pkg::reg_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Offer one media word, with a random gap first, and hold it until taken
   task automatic send_word(input logic [15:0] seq, input logic [63:0] data,
                            input logic [3:0] nb, input logic eop);
      while ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.seq_number    <= seq;
      req_bus.data_word     <= data;
      req_bus.valid_bytes   <= nb;
      req_bus.end_of_packet <= eop;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
   endtask

   // Random media packet; later words may carry stray sequence numbers
   task automatic send_packet(input logic [15:0] seq, input int unsigned nwords);
      logic [3:0]  nb;
      logic [15:0] wseq;
      int unsigned pick;
      for (int i = 0; i < nwords; i++) begin
         pick = $urandom_range(99);
         if (pick < 8) nb = 4'($urandom_range(15));
         else if (i == nwords - 1) nb = 4'($urandom_range(1, 8));
         else nb = 4'd8;
         wseq = (i == 0 || $urandom_range(9) != 0) ? seq : 16'($urandom);
         send_word(wseq, {$urandom, $urandom}, nb, i == nwords - 1);
      end
   endtask

   // Packets until the word target is reached; mostly short, rarely past the store
   task automatic stream_packets(input int unsigned word_target);
      int unsigned pick, nwords;
      while (words_sent < word_target) begin
         pick = $urandom_range(99);
         if (pick < 80) nwords = $urandom_range(1, 4);
         else if (pick < 97) nwords = $urandom_range(5, 16);
         else nwords = $urandom_range(62, 66);
         if ($urandom_range(19) == 0) media_seq = 16'($urandom);
         else media_seq = media_seq + 16'd1;
         send_packet(media_seq, nwords);
      end
   endtask

   // Drop valid, let every parity word arrive, then let the store write settle
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      wait (parity_backlog == 0);
      repeat (12) @(posedge clock);
   endtask

   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.seq_number    <= '0;
      req_bus.data_word     <= '0;
      req_bus.valid_bytes   <= '0;
      req_bus.end_of_packet <= 1'b0;
      csr_psel              <= 1'b0;
      csr_penable           <= 1'b0;
      csr_pwrite            <= 1'b0;
      csr_paddr             <= '0;
      csr_pwdata            <= '0;
      send_gap_pct   = 27;
      recv_stall_pct = 81;
      words_sent     = 0;
      media_seq      = 16'd200;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // One packet per group, all-ones stream id
      write_reg(xpfe_pkg::REG_GROUP_PKTS, 32'd1);
      write_reg(xpfe_pkg::REG_PARITY_SSRC, 32'hFFFF_FFFF);
      send_word(16'h0000, 64'h0, 4'd0, 1'b1);
      send_word(16'hFFFF, '1, 4'd8, 1'b1);
      send_word(16'h1234, {$urandom, $urandom}, 4'hF, 1'b1);
      send_word(16'h8000, {$urandom, $urandom}, 4'd8, 1'b0);
      send_word(16'h8000, {$urandom, $urandom}, 4'd0, 1'b0);
      send_word(16'h8000, {$urandom, $urandom}, 4'd3, 1'b1);
      wait_drained();

      // Three packets of differing length: shorter later, then longer
      write_reg(xpfe_pkg::REG_GROUP_PKTS, 32'd3);
      write_reg(xpfe_pkg::REG_PARITY_SSRC, 32'h0);
      send_word(16'd100, {$urandom, $urandom}, 4'd8, 1'b0);
      send_word(16'd100, {$urandom, $urandom}, 4'd5, 1'b1);
      send_word(16'd101, '1, 4'd8, 1'b1);
      send_word(16'd102, {$urandom, $urandom}, 4'd8, 1'b0);
      send_word(16'd102, {$urandom, $urandom}, 4'd8, 1'b0);
      send_word(16'd102, {$urandom, $urandom}, 4'd1, 1'b1);
      wait_drained();

      // Largest group, then lower it mid-group so the next packet end closes it
      write_reg(xpfe_pkg::REG_GROUP_PKTS, 32'd255);
      send_word(16'd300, {$urandom, $urandom}, 4'd8, 1'b1);
      send_word(16'd301, {$urandom, $urandom}, 4'd6, 1'b1);
      wait_drained();
      write_reg(xpfe_pkg::REG_GROUP_PKTS, 32'd2);
      send_word(16'd302, {$urandom, $urandom}, 4'd2, 1'b1);
      wait_drained();

      // Group size zero behaves as one
      write_reg(xpfe_pkg::REG_GROUP_PKTS, 32'd0);
      send_word(16'd400, 64'h0, 4'd8, 1'b1);
      wait_drained();

      write_reg(xpfe_pkg::REG_GROUP_PKTS, 32'd3);
      stream_packets(36);
      wait_drained();

      // Sender mostly idle, receiver mostly ready
      send_gap_pct   = 81;
      recv_stall_pct = 27;
      write_reg(xpfe_pkg::REG_GROUP_PKTS, 32'($urandom_range(2, 5)));
      write_reg(xpfe_pkg::REG_PARITY_SSRC, $urandom);
      stream_packets(words_sent + 26);
      wait_drained();

      // Full rate both ways, with one packet past the store
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      write_reg(xpfe_pkg::REG_GROUP_PKTS, 32'($urandom_range(1, 4)));
      write_reg(xpfe_pkg::REG_PARITY_SSRC, $urandom);
      media_seq = media_seq + 16'd1;
      send_packet(media_seq, $urandom_range(65, 68));
      stream_packets(words_sent + 4);

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> xor_parity_fec_encoder.f
+incdir+sv
sv/xpfe_pkg.sv
sv/xpfe_req_if.sv
sv/xpfe_rsp_if.sv
sv/xpfe_lane.sv
sv/xpfe_merge.sv
sv/xor_parity_fec_encoder.sv
bench/xpfe_parity_checker.sv
bench/tb.sv
